// File: rtl/core/bbm_pkg.sv
package bbm_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int POS_W       = 10;
    localparam int POS_LIMIT   = 1024;
    localparam int CFG_W       = 11;
    localparam int RAD_W       = 3;
    localparam int INDEX_W     = 2;
    localparam int COLSUM_W    = 12;
    localparam int WSUM_W      = 15;

    // Exact floor division by (2r+1)^2 through a scaled reciprocal.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 25;
    localparam int RECIP_N     = 9;
    localparam int PROD_W      = RECIP_W + WSUM_W;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;

    localparam logic [CFG_W-1:0] RADIUS_RESET = 11'd2;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    typedef enum logic [INDEX_W-1:0] {
        REG_RADIUS       = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } reg_index_t;

    // ceil(2^24 / (2r+1)^2) for r = 0 .. 8.
    localparam logic [RECIP_W-1:0] RECIP [RECIP_N] = '{
        25'd16777216, 25'd1864136, 25'd671089, 25'd342393, 25'd207127,
        25'd138655,   25'd99274,   25'd74566,  25'd58053
    };

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic             emit;
        logic             frame_end;
        logic [RAD_W-1:0] radius;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } tag_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] mean_value;
        logic [POS_W-1:0]      out_row;
        logic [POS_W-1:0]      out_col;
        logic                  frame_end;
    } result_t;

endpackage

// File: rtl/core/bbm_stream_if.sv
interface bbm_pix_if;
    logic                           valid;
    logic                           ready;
    logic [bbm_pkg::PIXEL_BITS-1:0] pixel;
    logic                           frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface bbm_mean_if;
    logic                           valid;
    logic                           ready;
    logic [bbm_pkg::PIXEL_BITS-1:0] mean_value;
    logic [bbm_pkg::POS_W-1:0]      out_row;
    logic [bbm_pkg::POS_W-1:0]      out_col;
    logic                           frame_end;

    modport source (output valid, output mean_value, output out_row, output out_col,
                    output frame_end, input ready);
    modport sink (input valid, input mean_value, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

// File: rtl/core/bbm_ram.sv
module bbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/bbm_column.sv
module bbm_column #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [bbm_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                           frame_start,
    input  bbm_pkg::cfg_t                  cfg,
    output logic                           cs_valid,
    output logic [bbm_pkg::COLSUM_W-1:0]   colsum,
    output bbm_pkg::tag_t                  cs_tag
);

    localparam int NSLOT = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(NSLOT);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WLIM  = (MAX_WIDTH < bbm_pkg::POS_LIMIT) ? MAX_WIDTH : bbm_pkg::POS_LIMIT;
    localparam int CSW   = bbm_pkg::COLSUM_W;
    localparam int PW    = bbm_pkg::POS_W;

    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [SW-1:0] slot_reg, slot_next;

    logic [bbm_pkg::RAD_W-1:0] r_eff;
    logic [3:0]                rad_ext;
    logic [bbm_pkg::RAD_W:0]   side;
    logic [bbm_pkg::RAD_W:0]   two_r;
    logic [bbm_pkg::CFG_W-1:0] w_eff;
    logic [bbm_pkg::CFG_W-1:0] h_eff;

    logic [PW-1:0]    cur_row;
    logic [PW-1:0]    cur_col;
    logic [SW-1:0]    cur_slot;
    logic [SW:0]      old_slot_sum;
    logic [SW-1:0]    old_slot;
    logic [CW+PW-1:0] col_ext;
    logic [CW-1:0]    cidx;
    logic [bbm_pkg::CFG_W-1:0] col_inc;
    logic [bbm_pkg::CFG_W-1:0] row_inc;
    logic [bbm_pkg::CFG_W-1:0] row_wide;
    logic [bbm_pkg::CFG_W-1:0] col_wide;

    logic                           s1_valid_reg;
    logic [bbm_pkg::PIXEL_BITS-1:0] s1_pix_reg;
    logic [CW-1:0]                  s1_cidx_reg;
    logic                           s1_first_reg;
    logic                           s1_sub_reg;
    bbm_pkg::tag_t                  s1_tag_reg;
    bbm_pkg::tag_t                  tag_next;

    logic           fw_valid_reg;
    logic [CW-1:0]  fw_cidx_reg;
    logic [CSW-1:0] fw_val_reg;

    logic [bbm_pkg::PIXEL_BITS-1:0] ls_rdata;
    logic [CSW-1:0]                 cs_rdata;
    logic [CSW-1:0]                 cs_base;
    logic [CSW-1:0]                 cs_drop;

    // Effective configuration.
    always_comb
    begin
        rad_ext = {1'b0, cfg.radius};
        r_eff   = (rad_ext > 4'(MAX_RADIUS)) ? bbm_pkg::RAD_W'(MAX_RADIUS) : cfg.radius;
        side    = {r_eff, 1'b1};
        two_r   = {r_eff, 1'b0};
        if (cfg.frame_width == '0)
        begin
            w_eff = bbm_pkg::CFG_W'(1);
        end
        else if (cfg.frame_width > bbm_pkg::CFG_W'(WLIM))
        begin
            w_eff = bbm_pkg::CFG_W'(WLIM);
        end
        else
        begin
            w_eff = cfg.frame_width;
        end
        if (cfg.frame_height == '0)
        begin
            h_eff = bbm_pkg::CFG_W'(1);
        end
        else if (cfg.frame_height > bbm_pkg::CFG_W'(bbm_pkg::POS_LIMIT))
        begin
            h_eff = bbm_pkg::CFG_W'(bbm_pkg::POS_LIMIT);
        end
        else
        begin
            h_eff = cfg.frame_height;
        end
    end

    // Position of the incoming pixel and the slot of the row leaving the window.
    always_comb
    begin
        cur_row  = frame_start ? '0 : row_reg;
        cur_col  = frame_start ? '0 : col_reg;
        cur_slot = frame_start ? '0 : slot_reg;
        row_wide = {1'b0, cur_row};
        col_wide = {1'b0, cur_col};

        old_slot_sum = {1'b0, cur_slot} + (SW + 1)'(NSLOT) - (SW + 1)'(side);
        if (old_slot_sum >= (SW + 1)'(NSLOT))
        begin
            old_slot_sum = old_slot_sum - (SW + 1)'(NSLOT);
        end
        old_slot = old_slot_sum[SW-1:0];

        col_ext = {{CW{1'b0}}, cur_col};
        cidx    = col_ext[CW-1:0];

        col_inc   = col_wide + bbm_pkg::CFG_W'(1);
        row_inc   = row_wide + bbm_pkg::CFG_W'(1);
        col_next  = col_inc[PW-1:0];
        row_next  = cur_row;
        slot_next = cur_slot;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= h_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_inc[PW-1:0];
                slot_next = (cur_slot == SW'(NSLOT - 1)) ? '0 : cur_slot + SW'(1);
            end
        end

        tag_next.emit      = (row_wide >= bbm_pkg::CFG_W'(two_r))
                             && (col_wide >= bbm_pkg::CFG_W'(two_r))
                             && (row_wide < h_eff) && (col_wide < w_eff);
        tag_next.frame_end = (row_wide == h_eff - bbm_pkg::CFG_W'(1))
                             && (col_wide == w_eff - bbm_pkg::CFG_W'(1));
        tag_next.radius    = r_eff;
        tag_next.row       = cur_row - PW'(r_eff);
        tag_next.col       = cur_col - PW'(r_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fw_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                row_reg  <= row_next;
                col_reg  <= col_next;
                slot_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel;
            s1_cidx_reg  <= cidx;
            s1_first_reg <= (cur_row == '0);
            s1_sub_reg   <= (row_wide >= bbm_pkg::CFG_W'(side));
            s1_tag_reg   <= tag_next;
        end
        if (s1_valid_reg)
        begin
            fw_cidx_reg <= s1_cidx_reg;
            fw_val_reg  <= colsum;
        end
    end

    bbm_ram #(
        .WIDTH (bbm_pkg::PIXEL_BITS),
        .DEPTH (NSLOT << CW)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr ({cur_slot, cidx}),
        .wdata (pixel),
        .raddr ({old_slot, cidx}),
        .rdata (ls_rdata)
    );

    bbm_ram #(
        .WIDTH (CSW),
        .DEPTH (1 << CW)
    ) u_column_sums (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_cidx_reg),
        .wdata (colsum),
        .raddr (cidx),
        .rdata (cs_rdata)
    );

    // The column sum runs down the frame: add the new pixel, drop the row that
    // left the window. The top row of a frame starts it afresh. A column sum
    // written in the cycle its read was issued is taken from the bypass.
    always_comb
    begin
        cs_base = (fw_valid_reg && (fw_cidx_reg == s1_cidx_reg)) ? fw_val_reg : cs_rdata;
        cs_drop = s1_sub_reg ? CSW'(ls_rdata) : '0;
        if (s1_first_reg)
        begin
            colsum = CSW'(s1_pix_reg);
        end
        else
        begin
            colsum = cs_base + CSW'(s1_pix_reg) - cs_drop;
        end
    end

    assign cs_valid = s1_valid_reg;
    assign cs_tag   = s1_tag_reg;

endmodule

// File: rtl/core/bbm_window.sv
module bbm_window #(
    parameter int MAX_RADIUS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cs_valid,
    input  logic [bbm_pkg::COLSUM_W-1:0] colsum,
    input  bbm_pkg::tag_t                cs_tag,
    output logic                         done,
    output logic                         emit,
    output bbm_pkg::result_t             res
);

    localparam int NSLOT = 2 * MAX_RADIUS + 1;

    logic [bbm_pkg::COLSUM_W-1:0] recent_reg [NSLOT];

    logic          s2_valid_reg;
    bbm_pkg::tag_t s2_tag_reg;
    logic          s3_valid_reg;
    bbm_pkg::tag_t s3_tag_reg;
    logic [bbm_pkg::WSUM_W-1:0] s3_ws_reg;
    logic          s4_valid_reg;
    bbm_pkg::tag_t s4_tag_reg;
    logic [bbm_pkg::PROD_W-1:0] s4_prod_reg;

    logic [bbm_pkg::WSUM_W-1:0]  ws;
    logic [bbm_pkg::RAD_W:0]     side;
    logic [bbm_pkg::RECIP_W-1:0] recip;
    logic [bbm_pkg::PROD_W-1:0]  prod_next;

    always_ff @(posedge clk)
    begin
        if (cs_valid)
        begin
            recent_reg[0] <= colsum;
            for (int i = 1; i < NSLOT; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

    // Sum of the newest 2r+1 column sums.
    always_comb
    begin
        side = {s2_tag_reg.radius, 1'b1};
        ws   = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (i < int'(side))
            begin
                ws = ws + bbm_pkg::WSUM_W'(recent_reg[i]);
            end
        end
    end

    assign recip     = bbm_pkg::RECIP[{1'b0, s3_tag_reg.radius}];
    assign prod_next = bbm_pkg::PROD_W'(s3_ws_reg) * bbm_pkg::PROD_W'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= cs_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tag_reg  <= cs_tag;
        s3_tag_reg  <= s2_tag_reg;
        s3_ws_reg   <= ws;
        s4_tag_reg  <= s3_tag_reg;
        s4_prod_reg <= prod_next;
    end

    assign done           = s4_valid_reg;
    assign emit           = s4_tag_reg.emit;
    assign res.mean_value = s4_prod_reg[bbm_pkg::RECIP_SHIFT +: bbm_pkg::PIXEL_BITS];
    assign res.out_row    = s4_tag_reg.row;
    assign res.out_col    = s4_tag_reg.col;
    assign res.frame_end  = s4_tag_reg.frame_end;

endmodule

// File: rtl/core/bbm_fifo.sv
module bbm_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bbm_pkg::result_t push_data,
    input  logic             pop,
    output logic             not_empty,
    output bbm_pkg::result_t head
);

    bbm_pkg::result_t mem [bbm_pkg::FIFO_DEPTH];

    logic [bbm_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [bbm_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [bbm_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [bbm_pkg::FIFO_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + bbm_pkg::FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - bbm_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bbm_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bbm_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

endmodule

// File: rtl/core/box_blur_mean_filter.sv
// Streaming box filter over 8-bit grey pixels in raster order.
// Pixels enter on the pixels channel; a word with frame_start set is row 0,
// column 0 of a new frame, and the position also wraps by itself at the end
// of each frame. For every pixel whose (2r+1)x(2r+1) window lies inside the
// frame, one word leaves on the means channel: the floor of the window mean
// and the row and column of the window centre; frame_end marks the last one.
// Border pixels produce no word. Registers radius, frame_width and
// frame_height are written through wr_en / wr_index / wr_data between frames.
// Throughput is one pixel per clock. A result passes stages s1 to s4, then
// the queue. The line store and the column-sum memory each take one read and
// one write per pixel, which sets that rate. Results wait in an 8-word queue;
// pixels keeps ready high while fewer than 8 accepted pixels are still in
// flight or queued, so a stalled receiver holds the input back.
// Reset sets radius 2, width 640, height 480 and the position to the frame
// origin; the memories need no clearing and are written before they are read.
module box_blur_mean_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bbm_pix_if.sink                     pixels,
    bbm_mean_if.source                  means,
    input  logic                        wr_en,
    input  logic [bbm_pkg::INDEX_W-1:0] wr_index,
    input  logic [bbm_pkg::CFG_W-1:0]   wr_data
);

    logic [bbm_pkg::RAD_W-1:0] radius_reg;
    logic [bbm_pkg::CFG_W-1:0] width_reg;
    logic [bbm_pkg::CFG_W-1:0] height_reg;
    bbm_pkg::cfg_t             cfg;

    logic [bbm_pkg::FIFO_CNT_W-1:0] inflight_reg;
    logic [bbm_pkg::FIFO_CNT_W-1:0] inflight_next;

    logic                         accept;
    logic                         cs_valid;
    logic [bbm_pkg::COLSUM_W-1:0] colsum;
    bbm_pkg::tag_t                cs_tag;
    logic                         done;
    logic                         emit;
    bbm_pkg::result_t             res;
    logic                         pop;
    logic                         drop;
    logic                         not_empty;
    bbm_pkg::result_t             head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= bbm_pkg::RADIUS_RESET[bbm_pkg::RAD_W-1:0];
            width_reg  <= bbm_pkg::WIDTH_RESET;
            height_reg <= bbm_pkg::HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (bbm_pkg::reg_index_t'(wr_index))
                bbm_pkg::REG_RADIUS:       radius_reg <= wr_data[bbm_pkg::RAD_W-1:0];
                bbm_pkg::REG_FRAME_WIDTH:  width_reg  <= wr_data;
                bbm_pkg::REG_FRAME_HEIGHT: height_reg <= wr_data;
                default:                   ;
            endcase
        end
    end

    assign cfg.radius       = radius_reg;
    assign cfg.frame_width  = width_reg;
    assign cfg.frame_height = height_reg;

    // Every accepted pixel holds a queue place until its word is taken or it
    // leaves the pipeline without a result.
    assign pixels.ready = (inflight_reg < bbm_pkg::FIFO_CNT_W'(bbm_pkg::FIFO_DEPTH));
    assign accept       = pixels.valid && pixels.ready;
    assign pop          = not_empty && means.ready;
    assign drop         = done && !emit;

    always_comb
    begin
        inflight_next = inflight_reg
                        + bbm_pkg::FIFO_CNT_W'(accept)
                        - bbm_pkg::FIFO_CNT_W'(drop)
                        - bbm_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    bbm_column #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_column (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (pixels.pixel),
        .frame_start (pixels.frame_start),
        .cfg         (cfg),
        .cs_valid    (cs_valid),
        .colsum      (colsum),
        .cs_tag      (cs_tag)
    );

    bbm_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cs_valid (cs_valid),
        .colsum   (colsum),
        .cs_tag   (cs_tag),
        .done     (done),
        .emit     (emit),
        .res      (res)
    );

    bbm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (done && emit),
        .push_data (res),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    assign means.valid      = not_empty;
    assign means.mean_value = head.mean_value;
    assign means.out_row    = head.out_row;
    assign means.out_col    = head.out_col;
    assign means.frame_end  = head.frame_end;

endmodule
